// ===== sv/dmab_pkg.sv =====
// Package: constants and shared types for the dual moving average band-pass unit.
package dmab_pkg;

  // Sample format
  localparam int unsigned SampleW = 8;
  localparam logic [SampleW-1:0] CenterOffset = 8'h80;

  // Window lengths and derived shifts (floor of log2)
  localparam int unsigned ShortWindow = 16;
  localparam int unsigned LongWindow  = 4096;
  localparam int unsigned ShortShift  = $clog2(ShortWindow + 1) - 1;
  localparam int unsigned LongShift   = $clog2(LongWindow + 1) - 1;

  // Ring addressing and running sum widths
  localparam int unsigned AddrW     = $clog2(LongWindow);
  localparam int unsigned ShortSumW = SampleW + $clog2(ShortWindow);
  localparam int unsigned LongSumW  = SampleW + $clog2(LongWindow);

  localparam logic [AddrW-1:0] LastIdx    = AddrW'(LongWindow - 1);
  localparam logic [AddrW-1:0] ShortDist  = AddrW'(ShortWindow);
  localparam logic [AddrW-1:0] ShortWrapD = AddrW'(LongWindow - ShortWindow);

  // Channel interleave
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned CountW      = 4;
  localparam int unsigned PosW        = $clog2(MaxChannels);
  localparam logic [CountW-1:0] MaxCount = CountW'(MaxChannels);

  // Read request to the history ring
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] long_addr;
    logic [AddrW-1:0] short_addr;
  } ring_rd_req_t;

  // Write request to the history ring
  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [SampleW-1:0] data;
  } ring_wr_req_t;

  // Registered read data from the history ring
  typedef struct packed {
    logic [SampleW-1:0] long_data;
    logic [SampleW-1:0] short_data;
  } ring_rd_rsp_t;

endpackage

// ===== sv/dmab_ring.sv =====
// History ring: one write port, two registered read ports.
module dmab_ring (
  input  logic                  clk_i,
  input  dmab_pkg::ring_rd_req_t rd_req_i,
  input  dmab_pkg::ring_wr_req_t wr_req_i,
  output dmab_pkg::ring_rd_rsp_t rd_rsp_o
);

  logic [dmab_pkg::SampleW-1:0] mem_q [dmab_pkg::LongWindow];
  dmab_pkg::ring_rd_rsp_t       rd_rsp_q;

  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem_q[wr_req_i.addr] <= wr_req_i.data;
    end
  end

  // hold read data unless a new read is issued
  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_rsp_q.long_data  <= mem_q[rd_req_i.long_addr];
      rd_rsp_q.short_data <= mem_q[rd_req_i.short_addr];
    end
  end

  assign rd_rsp_o = rd_rsp_q;

endmodule

// ===== sv/dual_moving_average_bandpass_unit.sv =====
// Top level: difference-of-moving-averages band-pass filter on interleaved 8-bit audio.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / sample_in_i) carries one raw
//   offset-binary byte per item, channels interleaved. The byte at the first
//   position of each frame is filtered; all others pass through unchanged.
//   Output channel (out_valid_o / out_stall_i / sample_out_o) returns exactly
//   one item per input item, in order.
//   cfg_we_i / cfg_wdata_i write the channels-per-frame count (zero counts
//   as one, above eight counts as eight); write it only while the unit is idle.
// Timing:
//   One item per cycle sustained while the output is not stalled. An accepted
//   item passes the registered read of the history ring in the ring stage, then
//   the running sum update into the output register, which drives out_valid_o.
// Reset:
//   History reads as zero until each ring entry has been written once; a
//   wrap flag and the write index stand in for clearing, so no clearing pass
//   is needed and items are accepted straight after reset.
// Stall:
//   A held output keeps its byte; one more item may sit in the ring stage,
//   after which in_stall_o rises until the receiver takes the output.
module dual_moving_average_bandpass_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dmab_pkg::CountW-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dmab_pkg::SampleW-1:0]       sample_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dmab_pkg::SampleW-1:0]       sample_out_o
);

  localparam int unsigned SW  = dmab_pkg::SampleW;
  localparam int unsigned AW  = dmab_pkg::AddrW;
  localparam int unsigned SSW = dmab_pkg::ShortSumW;
  localparam int unsigned LSW = dmab_pkg::LongSumW;

  // Configuration and frame tracking
  logic [dmab_pkg::CountW-1:0] chan_count_q;
  logic [dmab_pkg::CountW-1:0] count_eff;
  logic [dmab_pkg::PosW-1:0]   chan_pos_q, chan_pos_d;
  logic [dmab_pkg::CountW-1:0] pos_inc;
  logic                        filter_now;

  // Ring write pointer; wrapped_q marks that every entry has been written
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic          wrapped_q, wrapped_d;
  logic [AW-1:0] short_idx;

  // Pipeline control
  logic in_accept;
  logic s1_adv, s1_move, out_adv;

  // Ring stage registers
  logic          s1_valid_q;
  logic          s1_filter_q;
  logic [SW-1:0] s1_sample_q;
  logic [AW-1:0] s1_idx_q;
  logic          s1_short_ok_q;
  logic          s1_long_ok_q;

  // Running sums
  logic signed [SSW-1:0] short_sum_q, short_sum_d;
  logic signed [LSW-1:0] long_sum_q, long_sum_d;
  logic signed [SSW-1:0] short_avg_full;
  logic signed [LSW-1:0] long_avg_full;
  logic [SW-1:0]         centered;
  logic [SW-1:0]         old_short, old_long;
  logic [SW-1:0]         filt_result;

  // Output register
  logic          out_valid_q;
  logic [SW-1:0] out_data_q;

  dmab_pkg::ring_rd_req_t rd_req;
  dmab_pkg::ring_wr_req_t wr_req;
  dmab_pkg::ring_rd_rsp_t rd_rsp;

  // ---------------------------------------------------------------- control
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_adv;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign in_accept  = in_valid_i && s1_adv;

  // Clamp the channel count into one to eight
  always_comb begin
    priority if (chan_count_q == '0) begin
      count_eff = dmab_pkg::CountW'(1);
    end else if (chan_count_q > dmab_pkg::MaxCount) begin
      count_eff = dmab_pkg::MaxCount;
    end else begin
      count_eff = chan_count_q;
    end
  end

  assign filter_now = (chan_pos_q == '0);
  assign pos_inc    = {1'b0, chan_pos_q} + dmab_pkg::CountW'(1);

  // Advance the frame position; a position no longer below the count returns to zero
  always_comb begin
    chan_pos_d = chan_pos_q;
    if (in_accept) begin
      if (pos_inc >= count_eff) begin
        chan_pos_d = '0;
      end else begin
        chan_pos_d = pos_inc[dmab_pkg::PosW-1:0];
      end
    end
  end

  // Advance the ring pointer on each filtered item
  always_comb begin
    wr_idx_d  = wr_idx_q;
    wrapped_d = wrapped_q;
    if (in_accept && filter_now) begin
      if (wr_idx_q == dmab_pkg::LastIdx) begin
        wr_idx_d  = '0;
        wrapped_d = 1'b1;
      end else begin
        wr_idx_d = wr_idx_q + AW'(1);
      end
    end
  end

  assign short_idx = (wr_idx_q >= dmab_pkg::ShortDist) ? wr_idx_q - dmab_pkg::ShortDist
                                                       : wr_idx_q + dmab_pkg::ShortWrapD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= dmab_pkg::CountW'(1);
      chan_pos_q   <= '0;
      wr_idx_q     <= '0;
      wrapped_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chan_count_q <= cfg_wdata_i;
      end
      chan_pos_q <= chan_pos_d;
      wr_idx_q   <= wr_idx_d;
      wrapped_q  <= wrapped_d;
    end
  end

  // ------------------------------------------------------------ history ring
  // The next item reads entries other than the one the ring stage writes, so
  // no forwarding is needed: the long read is the slot after, the short one
  // lies a short window back.
  assign rd_req.en         = in_accept && filter_now;
  assign rd_req.long_addr  = wr_idx_q;
  assign rd_req.short_addr = short_idx;

  assign wr_req.en   = s1_move && s1_filter_q;
  assign wr_req.addr = s1_idx_q;
  assign wr_req.data = centered;

  dmab_ring u_ring (
    .clk_i    (clk_i),
    .rd_req_i (rd_req),
    .wr_req_i (wr_req),
    .rd_rsp_o (rd_rsp)
  );

  // -------------------------------------------------------------- ring stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_filter_q   <= filter_now;
      s1_sample_q   <= sample_in_i;
      s1_idx_q      <= wr_idx_q;
      // entries never written read as zero
      s1_short_ok_q <= wrapped_q || (wr_idx_q >= dmab_pkg::ShortDist);
      s1_long_ok_q  <= wrapped_q;
    end
  end

  // Centre the byte: subtracting the offset flips the top bit
  assign centered  = s1_sample_q - dmab_pkg::CenterOffset;
  assign old_short = s1_short_ok_q ? rd_rsp.short_data : '0;
  assign old_long  = s1_long_ok_q  ? rd_rsp.long_data  : '0;

  // Drop the oldest samples, add the new one
  assign short_sum_d = short_sum_q
                     - {{(SSW-SW){old_short[SW-1]}}, old_short}
                     + {{(SSW-SW){centered[SW-1]}}, centered};
  assign long_sum_d  = long_sum_q
                     - {{(LSW-SW){old_long[SW-1]}}, old_long}
                     + {{(LSW-SW){centered[SW-1]}}, centered};

  // Floor averages; only the low byte of the difference survives the wrap
  assign short_avg_full = short_sum_d >>> dmab_pkg::ShortShift;
  assign long_avg_full  = long_sum_d >>> dmab_pkg::LongShift;
  assign filt_result    = short_avg_full[SW-1:0] - long_avg_full[SW-1:0]
                        + dmab_pkg::CenterOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_sum_q <= '0;
      long_sum_q  <= '0;
    end else if (s1_move && s1_filter_q) begin
      short_sum_q <= short_sum_d;
      long_sum_q  <= long_sum_d;
    end
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= s1_filter_q ? filt_result : s1_sample_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule

// ===== sv/dmab_checker.sv =====
// Checker: port-level properties of the band-pass unit, bound to the top level.
module dmab_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [dmab_pkg::SampleW-1:0] sample_out_o
);

  // A held output item stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A held output item keeps its byte
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_out_o))
    else $error("output byte changed while stalled");

  // Input back-pressure only arises from a stalled, full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // An accepted item is followed by a valid output, past the ring stage and output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind dual_moving_average_bandpass_unit dmab_checker u_dmab_checker (.*);
